// ----- hdl/ray_sphere_pixel_shader_defines.svh -----
// Assertion helpers shared by the shader modules.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef RAY_SPHERE_PIXEL_SHADER_DEFINES_SVH
`define RAY_SPHERE_PIXEL_SHADER_DEFINES_SVH

// The expression must never be true outside reset.
`define RSPS_ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("rsps: forbidden condition seen");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define RSPS_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rsps: implication violated");

`endif

// ----- hdl/rsps_pkg.sv -----
`default_nettype none
package rsps_pkg;

   localparam int MAX_SPHERES = 4;
   localparam int FRAC_BITS   = 8;

   localparam int COORD_W = 16;
   localparam int DIM_W   = 13;
   localparam int PIX_W   = 12;
   localparam int COLOR_W = 8;
   localparam int RGB_W   = 3 * COLOR_W;
   localparam int SLOT_W  = 2;
   localparam int ACT_W   = 3;

   localparam int IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
   localparam int CNT_W = $clog2(MAX_SPHERES + 1);

   // Datapath widths follow from the fraction width.
   localparam int DIR_W  = FRAC_BITS + 2;
   localparam int MUL_W  = (FRAC_BITS + 14 > 24) ? FRAC_BITS + 14 : 24;
   localparam int SQ_W   = 2 * FRAC_BITS + 28;
   localparam int ROOT_W = SQ_W / 2;
   localparam int ACC_W  = (SQ_W + 4 > 2 * MUL_W) ? SQ_W + 4 : 2 * MUL_W;
   localparam int DIV_W  = (2 * FRAC_BITS + 14 > FRAC_BITS + 24) ?
                           2 * FRAC_BITS + 14 : FRAC_BITS + 24;
   localparam int SQ_CNT_W  = $clog2(ROOT_W);
   localparam int DIV_CNT_W = $clog2(DIV_W);
   localparam int ONE       = 1 << FRAC_BITS;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Request kinds.
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_TRACE = 1'b1;

   // Register indexes.
   localparam logic [1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_CAMERA_Z       = 2'd2;
   localparam logic [1:0] CSR_ACTIVE_SPHERES = 2'd3;

   // One classified request as it travels from the front to the back.
   typedef struct packed {
      logic                      action;
      logic [SLOT_W-1:0]         slot;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic [COORD_W-1:0]        radius;
      logic [RGB_W-1:0]          color;
      logic signed [DIR_W-1:0]   dir_x;
      logic signed [DIR_W-1:0]   dir_y;
      logic signed [DIR_W-1:0]   dir_z;
   } cmd_type;

   // Divide by the fixed-point one, rounding toward zero.
   function automatic logic signed [ACC_W-1:0] trunc_frac(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0] mag;
      mag = (a < 0) ? -a : a;
      mag = mag >>> FRAC_BITS;
      return (a < 0) ? -mag : mag;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/rsps_div.sv -----
`default_nettype none
module rsps_div import rsps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   // Restoring divider, one quotient bit per cycle.
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     num_ff, num_in;
   logic [DIV_W-1:0]     den_ff, den_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W:0]       rem_t;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      rem_t   = {rem_ff, num_ff[DIV_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (rem_t >= {1'b0, den_ff}) begin
            rem_in = DIV_W'(rem_t - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_t[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ----- hdl/rsps_isqrt.sv -----
`default_nettype none
module rsps_isqrt import rsps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_W-1:0]   radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   // Digit-by-digit floor square root, one root bit per cycle.
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SQ_W-1:0]     op_ff, op_in;
   logic [ROOT_W:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [ROOT_W+2:0]   rem_t;
   logic [ROOT_W+2:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rem_t   = {rem_ff, op_ff[SQ_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         op_in   = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         op_in = op_ff << 2;
         if (rem_t >= trial) begin
            rem_in  = (ROOT_W + 1)'(rem_t - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_t[ROOT_W:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == SQ_CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      op_ff   <= op_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

// ----- hdl/rsps_queue.sv -----
`default_nettype none
`include "ray_sphere_pixel_shader_defines.svh"
module rsps_queue import rsps_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   `RSPS_ASSERT_NEVER(a_queue_overfill, count_ff > QCNT_W'(QUEUE_DEPTH))
   `RSPS_ASSERT_IMPLIES(a_queue_pop_nonempty, pop, count_ff != '0)

endmodule
`default_nettype wire

// ----- hdl/rsps_front.sv -----
`default_nettype none
module rsps_front import rsps_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_action,
   input  logic [PIX_W-1:0]          req_pixel_x,
   input  logic [PIX_W-1:0]          req_pixel_y,
   input  logic [SLOT_W-1:0]         req_sphere_slot,
   input  logic signed [COORD_W-1:0] req_center_x,
   input  logic signed [COORD_W-1:0] req_center_y,
   input  logic signed [COORD_W-1:0] req_center_z,
   input  logic [COORD_W-1:0]        req_sphere_radius_in,
   input  logic [COLOR_W-1:0]        req_color_red,
   input  logic [COLOR_W-1:0]        req_color_green,
   input  logic [COLOR_W-1:0]        req_color_blue,
   input  logic [DIM_W-1:0]          image_width,
   input  logic [DIM_W-1:0]          image_height,
   output logic                      q_push,
   output cmd_type                   q_data,
   input  logic                      q_full
);

   localparam logic [3:0] F_IDLE  = 4'd0;
   localparam logic [3:0] F_UDIV  = 4'd1;
   localparam logic [3:0] F_UWAIT = 4'd2;
   localparam logic [3:0] F_VDIV  = 4'd3;
   localparam logic [3:0] F_VWAIT = 4'd4;
   localparam logic [3:0] F_SUMU  = 4'd5;
   localparam logic [3:0] F_SUMV  = 4'd6;
   localparam logic [3:0] F_ROOT  = 4'd7;
   localparam logic [3:0] F_RWAIT = 4'd8;
   localparam logic [3:0] F_NDIV  = 4'd9;
   localparam logic [3:0] F_NWAIT = 4'd10;
   localparam logic [3:0] F_PUSH  = 4'd11;

   logic [3:0]              state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [PIX_W-1:0]        px_ff, px_in;
   logic [PIX_W-1:0]        py_ff, py_in;
   logic signed [MUL_W-1:0] u_ff, u_in;
   logic signed [MUL_W-1:0] v_ff, v_in;
   logic [SQ_W-1:0]         acc_ff, acc_in;
   logic [ROOT_W-1:0]       len_ff, len_in;
   logic [1:0]              k_ff, k_in;
   logic                    neg_ff, neg_in;

   logic [DIM_W-1:0]          wn, hn;
   logic signed [DIM_W+2:0]   diff_x, diff_y, diff_sel;
   logic signed [MUL_W-1:0]   comp, comp_abs, sq_sel;
   logic signed [2*MUL_W-1:0] sq;
   logic signed [MUL_W-1:0]   quo_s;
   logic signed [DIR_W-1:0]   quo_d;

   logic             div_start, div_done;
   logic [DIV_W-1:0] div_num, div_den, div_quo;
   logic             sq_start, sq_done;
   logic [ROOT_W-1:0] sq_root;

   rsps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   rsps_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (acc_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   // A zero image size counts as one pixel.
   assign wn = (image_width == '0) ? DIM_W'(1) : image_width;
   assign hn = (image_height == '0) ? DIM_W'(1) : image_height;

   assign diff_x = signed'({3'b000, px_ff, 1'b0}) - signed'({3'b000, wn});
   assign diff_y = signed'({3'b000, py_ff, 1'b0}) - signed'({3'b000, hn});
   assign diff_sel = (state_ff == F_UDIV) ? diff_x : diff_y;

   always_comb begin
      unique case (k_ff)
         2'd0:    comp = u_ff;
         2'd1:    comp = v_ff;
         default: comp = MUL_W'(ONE);
      endcase
   end
   assign comp_abs = (comp < 0) ? -comp : comp;

   assign sq_sel = (state_ff == F_SUMU) ? u_ff : v_ff;
   assign sq     = sq_sel * sq_sel;
   assign quo_s  = MUL_W'(signed'({1'b0, div_quo}));
   assign quo_d  = DIR_W'(quo_s);

   assign req_full = (state_ff != F_IDLE);
   assign q_data   = cmd_ff;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      u_in      = u_ff;
      v_in      = v_ff;
      acc_in    = acc_ff;
      len_in    = len_ff;
      k_in      = k_ff;
      neg_in    = neg_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      sq_start  = 1'b0;
      q_push    = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (req_push) begin
               cmd_in.action   = req_action;
               cmd_in.slot     = req_sphere_slot;
               cmd_in.center_x = req_center_x;
               cmd_in.center_y = req_center_y;
               cmd_in.center_z = req_center_z;
               cmd_in.radius   = req_sphere_radius_in;
               cmd_in.color    = {req_color_red, req_color_green, req_color_blue};
               px_in = req_pixel_x;
               py_in = req_pixel_y;
               state_in = (req_action == ACTION_TRACE) ? F_UDIV : F_PUSH;
            end
         end
         F_UDIV, F_VDIV: begin
            div_start = 1'b1;
            neg_in    = (diff_sel < 0);
            div_num   = DIV_W'(unsigned'((diff_sel < 0) ? -diff_sel : diff_sel)) << FRAC_BITS;
            div_den   = (state_ff == F_UDIV) ? DIV_W'({wn, 1'b0}) : DIV_W'({hn, 1'b0});
            state_in  = (state_ff == F_UDIV) ? F_UWAIT : F_VWAIT;
         end
         F_UWAIT: begin
            if (div_done) begin
               u_in     = neg_ff ? -quo_s : quo_s;
               state_in = F_VDIV;
            end
         end
         F_VWAIT: begin
            if (div_done) begin
               v_in     = neg_ff ? -quo_s : quo_s;
               acc_in   = SQ_W'(ONE * ONE);
               state_in = F_SUMU;
            end
         end
         F_SUMU: begin
            acc_in   = acc_ff + SQ_W'($unsigned(sq));
            state_in = F_SUMV;
         end
         F_SUMV: begin
            acc_in   = acc_ff + SQ_W'($unsigned(sq));
            state_in = F_ROOT;
         end
         F_ROOT: begin
            sq_start = 1'b1;
            state_in = F_RWAIT;
         end
         F_RWAIT: begin
            if (sq_done) begin
               len_in   = (sq_root == '0) ? ROOT_W'(1) : sq_root;
               k_in     = 2'd0;
               state_in = F_NDIV;
            end
         end
         F_NDIV: begin
            div_start = 1'b1;
            neg_in    = (comp < 0);
            div_num   = DIV_W'(unsigned'(comp_abs)) << FRAC_BITS;
            div_den   = DIV_W'(len_ff);
            state_in  = F_NWAIT;
         end
         F_NWAIT: begin
            if (div_done) begin
               unique case (k_ff)
                  2'd0:    cmd_in.dir_x = neg_ff ? -quo_d : quo_d;
                  2'd1:    cmd_in.dir_y = neg_ff ? -quo_d : quo_d;
                  default: cmd_in.dir_z = neg_ff ? -quo_d : quo_d;
               endcase
               if (k_ff == 2'd2) begin
                  state_in = F_PUSH;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = F_NDIV;
               end
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
      cmd_ff <= cmd_in;
      px_ff  <= px_in;
      py_ff  <= py_in;
      u_ff   <= u_in;
      v_ff   <= v_in;
      acc_ff <= acc_in;
      len_ff <= len_in;
      neg_ff <= neg_in;
   end

endmodule
`default_nettype wire

// ----- hdl/rsps_back.sv -----
`default_nettype none
`include "ray_sphere_pixel_shader_defines.svh"
module rsps_back import rsps_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_empty,
   input  cmd_type                   q_data,
   output logic                      q_pop,
   input  logic signed [COORD_W-1:0] camera_z,
   input  logic [ACT_W-1:0]          active_spheres,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [COLOR_W-1:0]        rsp_red,
   output logic [COLOR_W-1:0]        rsp_green,
   output logic [COLOR_W-1:0]        rsp_blue,
   output logic                      rsp_hit
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_LOAD  = 5'd1;
   localparam logic [4:0] S_DOT   = 5'd2;
   localparam logic [4:0] S_BH    = 5'd3;
   localparam logic [4:0] S_OO    = 5'd4;
   localparam logic [4:0] S_DISC  = 5'd5;
   localparam logic [4:0] S_DCHK  = 5'd6;
   localparam logic [4:0] S_ROOT1 = 5'd7;
   localparam logic [4:0] S_TCHK  = 5'd8;
   localparam logic [4:0] S_PM    = 5'd9;
   localparam logic [4:0] S_PA    = 5'd10;
   localparam logic [4:0] S_NUM   = 5'd11;
   localparam logic [4:0] S_PP    = 5'd12;
   localparam logic [4:0] S_PS    = 5'd13;
   localparam logic [4:0] S_ROOT2 = 5'd14;
   localparam logic [4:0] S_IDIV  = 5'd15;
   localparam logic [4:0] S_DIVW  = 5'd16;
   localparam logic [4:0] S_NEXT  = 5'd17;
   localparam logic [4:0] S_OUT   = 5'd18;

   localparam int PROD_W = COLOR_W + FRAC_BITS + 1;

   // Sphere table, valid only for entries that have been loaded.
   logic signed [COORD_W-1:0] tcx_ff [MAX_SPHERES];
   logic signed [COORD_W-1:0] tcy_ff [MAX_SPHERES];
   logic signed [COORD_W-1:0] tcz_ff [MAX_SPHERES];
   logic [COORD_W-1:0]        trad_ff [MAX_SPHERES];
   logic [RGB_W-1:0]          tcol_ff [MAX_SPHERES];

   logic [4:0]                state_ff, state_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic [1:0]                k_ff, k_in;
   logic signed [DIR_W-1:0]   d_ff [3];
   logic signed [DIR_W-1:0]   d_in [3];
   logic signed [COORD_W:0]   oc_ff [3];
   logic signed [COORD_W:0]   oc_in [3];
   logic signed [MUL_W-1:0]   p_ff [3];
   logic signed [MUL_W-1:0]   p_in [3];
   logic [COORD_W-1:0]        r_ff, r_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [MUL_W-1:0]   bh_ff, bh_in;
   logic signed [MUL_W-1:0]   t_ff, t_in;
   logic signed [MUL_W-1:0]   best_t_ff, best_t_in;
   logic [RGB_W-1:0]          best_color_ff, best_color_in;
   logic                      found_ff, found_in;
   logic [FRAC_BITS:0]        intens_ff, intens_in;
   logic signed [MUL_W+1:0]   num_ff, num_in;
   logic [ROOT_W-1:0]         den_ff, den_in;

   logic                      out_valid_ff, out_valid_in;
   logic [COLOR_W-1:0]        red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic                      hit_ff, hit_in;
   logic                      out_load;

   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] prod;
   logic signed [ACC_W-1:0]   prod_x, acc3;
   logic [IDX_W-1:0]          idx;
   logic [IDX_W-1:0]          load_slot;
   logic                      load_we;

   logic              sq_start, sq_done;
   logic [SQ_W-1:0]   sq_rad;
   logic [ROOT_W-1:0] sq_root;
   logic              div_start, div_done;
   logic [DIV_W-1:0]  div_num, div_den, div_quo;
   logic [PROD_W-1:0] mr, mg, mb;

   rsps_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .done     (sq_done),
      .root     (sq_root)
   );

   rsps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign idx       = idx_ff[IDX_W-1:0];
   assign load_slot = IDX_W'(q_data.slot);

   // One shared multiplier; its operands follow the sequencer state.
   always_comb begin
      unique case (state_ff)
         S_DOT: begin
            mul_a = MUL_W'(oc_ff[k_ff]);
            mul_b = MUL_W'(d_ff[k_ff]);
         end
         S_BH: begin
            mul_a = MUL_W'(signed'({1'b0, r_ff}));
            mul_b = MUL_W'(signed'({1'b0, r_ff}));
         end
         S_OO: begin
            mul_a = MUL_W'(oc_ff[k_ff]);
            mul_b = MUL_W'(oc_ff[k_ff]);
         end
         S_DISC: begin
            mul_a = bh_ff;
            mul_b = bh_ff;
         end
         S_PM: begin
            mul_a = MUL_W'(d_ff[k_ff]);
            mul_b = t_ff;
         end
         S_PP: begin
            mul_a = p_ff[k_ff];
            mul_b = p_ff[k_ff];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod   = mul_a * mul_b;
   assign prod_x = ACC_W'(prod);
   assign acc3   = acc_ff + (acc_ff <<< 1);
   assign sq_rad = (state_ff == S_PS) ? acc3[SQ_W-1:0] : acc_ff[SQ_W-1:0];
   assign div_num = DIV_W'($unsigned(num_ff)) << FRAC_BITS;
   assign div_den = DIV_W'(den_ff);

   assign mr = PROD_W'(best_color_ff[RGB_W-1 -: COLOR_W]) * PROD_W'(intens_ff);
   assign mg = PROD_W'(best_color_ff[COLOR_W +: COLOR_W]) * PROD_W'(intens_ff);
   assign mb = PROD_W'(best_color_ff[COLOR_W-1:0]) * PROD_W'(intens_ff);

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      d_in          = d_ff;
      oc_in         = oc_ff;
      p_in          = p_ff;
      r_in          = r_ff;
      acc_in        = acc_ff;
      bh_in         = bh_ff;
      t_in          = t_ff;
      best_t_in     = best_t_ff;
      best_color_in = best_color_ff;
      found_in      = found_ff;
      intens_in     = intens_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      q_pop         = 1'b0;
      load_we       = 1'b0;
      sq_start      = 1'b0;
      div_start     = 1'b0;
      out_load      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_data.action == ACTION_LOAD) begin
                  load_we = (int'(q_data.slot) < MAX_SPHERES);
               end else begin
                  d_in[0]  = q_data.dir_x;
                  d_in[1]  = q_data.dir_y;
                  d_in[2]  = q_data.dir_z;
                  n_in     = (int'(active_spheres) > MAX_SPHERES) ?
                             CNT_W'(MAX_SPHERES) : CNT_W'(active_spheres);
                  idx_in   = '0;
                  found_in = 1'b0;
                  state_in = (n_in == '0) ? S_OUT : S_LOAD;
               end
            end
         end
         S_LOAD: begin
            oc_in[0] = -(COORD_W + 1)'(tcx_ff[idx]);
            oc_in[1] = -(COORD_W + 1)'(tcy_ff[idx]);
            oc_in[2] = (COORD_W + 1)'(camera_z) - (COORD_W + 1)'(tcz_ff[idx]);
            r_in     = trad_ff[idx];
            acc_in   = '0;
            k_in     = 2'd0;
            state_in = S_DOT;
         end
         S_DOT: begin
            acc_in = acc_ff + prod_x;
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               state_in = S_BH;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         S_BH: begin
            bh_in    = MUL_W'(trunc_frac(acc_ff));
            acc_in   = -prod_x;
            state_in = S_OO;
         end
         S_OO: begin
            acc_in = acc_ff + prod_x;
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               state_in = S_DISC;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         S_DISC: begin
            acc_in   = prod_x - acc_ff;
            state_in = S_DCHK;
         end
         S_DCHK: begin
            if (acc_ff < 0) begin
               state_in = S_NEXT;
            end else begin
               sq_start = 1'b1;
               state_in = S_ROOT1;
            end
         end
         S_ROOT1: begin
            if (sq_done) begin
               t_in     = -bh_ff - MUL_W'(signed'({1'b0, sq_root}));
               state_in = S_TCHK;
            end
         end
         S_TCHK: begin
            if (t_ff <= 0 || (found_ff && t_ff >= best_t_ff)) begin
               state_in = S_NEXT;
            end else begin
               found_in      = 1'b1;
               best_t_in     = t_ff;
               best_color_in = tcol_ff[idx];
               k_in          = 2'd0;
               state_in      = S_PM;
            end
         end
         S_PM: begin
            acc_in   = prod_x;
            state_in = S_PA;
         end
         S_PA: begin
            p_in[k_ff] = MUL_W'(oc_ff[k_ff]) + MUL_W'(trunc_frac(acc_ff));
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               state_in = S_NUM;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_PM;
            end
         end
         S_NUM: begin
            num_in   = (MUL_W + 2)'(p_ff[0]) - (MUL_W + 2)'(p_ff[1]) - (MUL_W + 2)'(p_ff[2]);
            acc_in   = '0;
            state_in = S_PP;
         end
         S_PP: begin
            acc_in = acc_ff + prod_x;
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               state_in = S_PS;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         S_PS: begin
            sq_start = 1'b1;
            state_in = S_ROOT2;
         end
         S_ROOT2: begin
            if (sq_done) begin
               den_in = sq_root;
               if (num_ff <= 0 || sq_root == '0) begin
                  intens_in = '0;
                  state_in  = S_NEXT;
               end else begin
                  state_in = S_IDIV;
               end
            end
         end
         S_IDIV: begin
            div_start = 1'b1;
            state_in  = S_DIVW;
         end
         S_DIVW: begin
            if (div_done) begin
               intens_in = (div_quo > DIV_W'(ONE)) ? (FRAC_BITS + 1)'(ONE) :
                           div_quo[FRAC_BITS:0];
               state_in  = S_NEXT;
            end
         end
         S_NEXT: begin
            if (idx_ff + 1'b1 == n_ff) begin
               state_in = S_OUT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_LOAD;
            end
         end
         S_OUT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      hit_in   = hit_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         hit_in   = found_ff;
         red_in   = found_ff ? mr[FRAC_BITS +: COLOR_W] : '0;
         green_in = found_ff ? mg[FRAC_BITS +: COLOR_W] : '0;
         blue_in  = found_ff ? mb[FRAC_BITS +: COLOR_W] : '0;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
         n_ff         <= '0;
         k_ff         <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         found_ff     <= found_in;
      end
      d_ff          <= d_in;
      oc_ff         <= oc_in;
      p_ff          <= p_in;
      r_ff          <= r_in;
      acc_ff        <= acc_in;
      bh_ff         <= bh_in;
      t_ff          <= t_in;
      best_t_ff     <= best_t_in;
      best_color_ff <= best_color_in;
      intens_ff     <= intens_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      red_ff        <= red_in;
      green_ff      <= green_in;
      blue_ff       <= blue_in;
      hit_ff        <= hit_in;
      if (load_we) begin
         tcx_ff[load_slot]  <= q_data.center_x;
         tcy_ff[load_slot]  <= q_data.center_y;
         tcz_ff[load_slot]  <= q_data.center_z;
         trad_ff[load_slot] <= q_data.radius;
         tcol_ff[load_slot] <= q_data.color;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;
   assign rsp_hit   = hit_ff;

   `RSPS_ASSERT_IMPLIES(a_back_no_overwrite, out_load && out_valid_ff, rsp_pop)
   `RSPS_ASSERT_NEVER(a_back_idx_range, state_ff == S_NEXT && idx_ff >= n_ff)

endmodule
`default_nettype wire

// ----- hdl/ray_sphere_pixel_shader.sv -----
// A load request is registered in the front, pushed into the queue and written into
// the sphere table when the back pops it. A trace request is normalized in the front,
// then intersected in the back one active sphere after another. The front takes a new
// request once it has queued the last; the serial divider and the serial square root
// set the pace of both. Synchronous active-high reset clears all control state and
// restores the register defaults; sphere table contents stay undefined until loaded.
`default_nettype none
module ray_sphere_pixel_shader import rsps_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // Request channel.
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_action,
   input  logic [PIX_W-1:0]          req_pixel_x,
   input  logic [PIX_W-1:0]          req_pixel_y,
   input  logic [SLOT_W-1:0]         req_sphere_slot,
   input  logic signed [COORD_W-1:0] req_center_x,
   input  logic signed [COORD_W-1:0] req_center_y,
   input  logic signed [COORD_W-1:0] req_center_z,
   input  logic [COORD_W-1:0]        req_sphere_radius_in,
   input  logic [COLOR_W-1:0]        req_color_red,
   input  logic [COLOR_W-1:0]        req_color_green,
   input  logic [COLOR_W-1:0]        req_color_blue,
   // Result channel.
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [COLOR_W-1:0]        rsp_red,
   output logic [COLOR_W-1:0]        rsp_green,
   output logic [COLOR_W-1:0]        rsp_blue,
   output logic                      rsp_hit,
   // Register write port.
   input  logic                      csr_write,
   input  logic [1:0]                csr_index,
   input  logic [COORD_W-1:0]        csr_data
);

   // The front computes the normalized ray direction for every trace request and
   // passes load requests through unchanged. The back owns the sphere table and
   // walks the active spheres with its own divider and square root, so one pixel
   // can be normalized while the previous one is still being intersected.

   logic [DIM_W-1:0]          width_ff, width_in;
   logic [DIM_W-1:0]          height_ff, height_in;
   logic signed [COORD_W-1:0] camz_ff, camz_in;
   logic [ACT_W-1:0]          active_ff, active_in;

   logic    q_push, q_full, q_pop, q_empty;
   cmd_type q_wdata, q_rdata;

   // Register writes must come only while the block is idle; unchecked, no hazard logic.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      camz_in   = camz_ff;
      active_in = active_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:    width_in  = csr_data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:   height_in = csr_data[DIM_W-1:0];
            CSR_CAMERA_Z:       camz_in   = csr_data;
            CSR_ACTIVE_SPHERES: active_in = csr_data[ACT_W-1:0];
            default:            width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(800);
         height_ff <= DIM_W'(600);
         camz_ff   <= -COORD_W'(1280);
         active_ff <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         camz_ff   <= camz_in;
         active_ff <= active_in;
      end
   end

   rsps_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_action           (req_action),
      .req_pixel_x          (req_pixel_x),
      .req_pixel_y          (req_pixel_y),
      .req_sphere_slot      (req_sphere_slot),
      .req_center_x         (req_center_x),
      .req_center_y         (req_center_y),
      .req_center_z         (req_center_z),
      .req_sphere_radius_in (req_sphere_radius_in),
      .req_color_red        (req_color_red),
      .req_color_green      (req_color_green),
      .req_color_blue       (req_color_blue),
      .image_width          (width_ff),
      .image_height         (height_ff),
      .q_push               (q_push),
      .q_data               (q_wdata),
      .q_full               (q_full)
   );

   // Short queue that lets the front run ahead of the back by two requests.
   rsps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   rsps_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_data         (q_rdata),
      .q_pop          (q_pop),
      .camera_z       (camz_ff),
      .active_spheres (active_ff),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_hit        (rsp_hit)
   );

endmodule
`default_nettype wire

// ----- tb/ray_sphere_pixel_shader_tb.sv -----
`default_nettype none
module ray_sphere_pixel_shader_tb import rsps_pkg::*; ();

   // Watchdog limit in cycles without any accepted request or result; the longest stall
   // during a trace with four active spheres is far shorter.
   localparam int STALL_LIMIT = 20000;
   // Time allowed after the last result for a load to settle in the sphere table.
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic                      action;
      logic [PIX_W-1:0]          pixel_x;
      logic [PIX_W-1:0]          pixel_y;
      logic [SLOT_W-1:0]         slot;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic [COORD_W-1:0]        radius;
      logic [COLOR_W-1:0]        red;
      logic [COLOR_W-1:0]        green;
      logic [COLOR_W-1:0]        blue;
   } request_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               hit;
   } pixel_type;

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   request_type req_item;
   logic rsp_empty;
   logic rsp_pop;
   logic [COLOR_W-1:0] rsp_red;
   logic [COLOR_W-1:0] rsp_green;
   logic [COLOR_W-1:0] rsp_blue;
   logic rsp_hit;
   logic csr_write;
   logic [1:0] csr_index;
   logic [COORD_W-1:0] csr_data;

   ray_sphere_pixel_shader dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_action(req_item.action),
      .req_pixel_x(req_item.pixel_x),
      .req_pixel_y(req_item.pixel_y),
      .req_sphere_slot(req_item.slot),
      .req_center_x(req_item.center_x),
      .req_center_y(req_item.center_y),
      .req_center_z(req_item.center_z),
      .req_sphere_radius_in(req_item.radius),
      .req_color_red(req_item.red),
      .req_color_green(req_item.green),
      .req_color_blue(req_item.blue),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_red(rsp_red),
      .rsp_green(rsp_green),
      .rsp_blue(rsp_blue),
      .rsp_hit(rsp_hit),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // The bench's copy of the shader's registers and sphere table; the table is updated when a
   // request is accepted, so that the expected pixel is known at that moment.
   logic [DIM_W-1:0]          shade_width;
   logic [DIM_W-1:0]          shade_height;
   logic signed [COORD_W-1:0] shade_camera_z;
   logic [ACT_W-1:0]          shade_active;
   request_type               sphere_table [MAX_SPHERES];

   request_type pending_requests [$];
   pixel_type   expected_pixels [$];
   int          error_count;
   int          stall_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $realtime, what);
      error_count++;
   endtask

   function automatic longint floor_root(input longint n);
      longint root, bit_value;
      root = 0;
      bit_value = longint'(1) << 62;
      while (bit_value > n) bit_value >>= 2;
      while (bit_value != 0) begin
         if (n >= root + bit_value) begin
            n -= root + bit_value;
            root = (root >> 1) + bit_value;
         end else begin
            root >>= 1;
         end
         bit_value >>= 2;
      end
      return root;
   endfunction

   // Shade one pixel: nearest positive near root over the active spheres, then
   // Lambert intensity against the light direction (1,-1,-1)/sqrt3. SystemVerilog
   // integer division truncates toward zero, as the hardware's divider does.
   function automatic pixel_type shade_pixel(input request_type item);
      longint unit_one, w, h, len, best_t, intensity;
      longint dir [3];
      longint oc [3];
      longint p [3];
      longint bh, c, disc, t, r, num, den;
      int count;
      bit found;
      request_type best;
      pixel_type pixel;
      unit_one = longint'(ONE);
      found = 1'b0;
      best_t = 0;
      intensity = 0;
      best = '0;
      w = (shade_width == 0) ? 1 : longint'(shade_width);
      h = (shade_height == 0) ? 1 : longint'(shade_height);
      dir[0] = ((2 * longint'(item.pixel_x) - w) * unit_one) / (2 * w);
      dir[1] = ((2 * longint'(item.pixel_y) - h) * unit_one) / (2 * h);
      dir[2] = unit_one;
      len = floor_root(dir[0] * dir[0] + dir[1] * dir[1] + dir[2] * dir[2]);
      if (len == 0) len = 1;
      for (int k = 0; k < 3; k++) dir[k] = (dir[k] * unit_one) / len;
      count = (shade_active < MAX_SPHERES) ? int'(shade_active) : MAX_SPHERES;
      for (int i = 0; i < count; i++) begin
         oc[0] = -longint'(sphere_table[i].center_x);
         oc[1] = -longint'(sphere_table[i].center_y);
         oc[2] = longint'(shade_camera_z) - longint'(sphere_table[i].center_z);
         r = longint'(sphere_table[i].radius);
         bh = (oc[0] * dir[0] + oc[1] * dir[1] + oc[2] * dir[2]) / unit_one;
         c = oc[0] * oc[0] + oc[1] * oc[1] + oc[2] * oc[2] - r * r;
         disc = bh * bh - c;
         if (disc < 0) continue;
         t = -bh - floor_root(disc);
         // A camera inside the sphere leaves the near root at or behind it.
         if (t <= 0) continue;
         if (found && t >= best_t) continue;
         found = 1'b1;
         best_t = t;
         best = sphere_table[i];
         for (int k = 0; k < 3; k++) p[k] = oc[k] + (dir[k] * t) / unit_one;
         num = p[0] - p[1] - p[2];
         den = floor_root(3 * (p[0] * p[0] + p[1] * p[1] + p[2] * p[2]));
         if (num <= 0 || den == 0) begin
            intensity = 0;
         end else begin
            intensity = (num * unit_one) / den;
            if (intensity > unit_one) intensity = unit_one;
         end
      end
      pixel = '0;
      if (found) begin
         pixel.red   = COLOR_W'((longint'(best.red) * intensity) >> FRAC_BITS);
         pixel.green = COLOR_W'((longint'(best.green) * intensity) >> FRAC_BITS);
         pixel.blue  = COLOR_W'((longint'(best.blue) * intensity) >> FRAC_BITS);
         pixel.hit   = 1'b1;
      end
      return pixel;
   endfunction

   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Driver: presents the queued requests, with random gaps between them.
   int push_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         req_item <= '0;
         push_gap <= 0;
      end else begin
         if (req_push && !req_full) begin
            if (req_item.action == ACTION_LOAD) begin
               sphere_table[req_item.slot] = req_item;
            end else begin
               expected_pixels.push_back(shade_pixel(req_item));
            end
         end
         if (!req_push || !req_full) begin
            if (push_gap > 0) begin
               req_push <= 1'b0;
               push_gap <= push_gap - 1;
            end else if (pending_requests.size() > 0) begin
               req_item <= pending_requests.pop_front();
               req_push <= 1'b1;
               push_gap <= idle_length();
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Monitor: pops results with random stalls and checks them in order.
   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("pixel with no pending trace");
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_red !== want.red)
                  report_mismatch($sformatf("red %0d, want %0d", rsp_red, want.red));
               if (rsp_green !== want.green)
                  report_mismatch($sformatf("green %0d, want %0d", rsp_green, want.green));
               if (rsp_blue !== want.blue)
                  report_mismatch($sformatf("blue %0d, want %0d", rsp_blue, want.blue));
               if (rsp_hit !== want.hit)
                  report_mismatch($sformatf("hit %0b, want %0b", rsp_hit, want.hit));
            end
         end
         rsp_pop <= ($urandom_range(0, 9) < 7) ? 1'b1 : ($urandom_range(0, 19) == 0);
      end
   end

   // Watchdog: a cycle counts as stalled when neither side accepts anything.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic write_register(input logic [1:0] index, input logic [COORD_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (index)
         CSR_IMAGE_WIDTH:    shade_width = value[DIM_W-1:0];
         CSR_IMAGE_HEIGHT:   shade_height = value[DIM_W-1:0];
         CSR_CAMERA_Z:       shade_camera_z = value;
         CSR_ACTIVE_SPHERES: shade_active = value[ACT_W-1:0];
         default: ;
      endcase
   endtask

   // Waits until every queued request is accepted and every pixel has come back.
   task automatic drain();
      while (pending_requests.size() > 0 || req_push || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic request_type load_request(input int slot, input int cx, input int cy,
                                                input int cz, input int radius);
      request_type item;
      item = '0;
      item.action   = ACTION_LOAD;
      item.slot     = SLOT_W'(slot);
      item.center_x = COORD_W'(cx);
      item.center_y = COORD_W'(cy);
      item.center_z = COORD_W'(cz);
      item.radius   = COORD_W'(radius);
      item.red      = COLOR_W'($urandom);
      item.green    = COLOR_W'($urandom);
      item.blue     = COLOR_W'($urandom);
      // Pixel fields are ignored by a load, but they still get exercised.
      item.pixel_x  = PIX_W'($urandom);
      item.pixel_y  = PIX_W'($urandom);
      return item;
   endfunction

   function automatic request_type trace_request(input int x, input int y);
      request_type item;
      item = request_type'({$urandom, $urandom, $urandom, $urandom});
      item.action  = ACTION_TRACE;
      item.pixel_x = PIX_W'(x);
      item.pixel_y = PIX_W'(y);
      return item;
   endfunction

   // A sphere placed mostly in front of the camera, so that traces often hit.
   function automatic request_type visible_sphere(input int slot);
      return load_request(slot, $urandom_range(0, 1536) - 768, $urandom_range(0, 1536) - 768,
                          $urandom_range(0, 2560) - 768, $urandom_range(64, 900));
   endfunction

   function automatic request_type any_sphere(input int slot);
      return load_request(slot, $urandom, $urandom, $urandom, $urandom);
   endfunction

   int unsigned dims [4][2] = '{'{800, 600}, '{1, 1}, '{4096, 4096}, '{64, 48}};
   int phase_active;
   int dx, dy;

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_item = '0;
      rsp_pop = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_data = '0;
      error_count = 0;
      stall_cycles = 0;
      shade_width = 13'd800;
      shade_height = 13'd600;
      shade_camera_z = -16'sd1280;
      shade_active = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part under reset settings: no active sphere gives background,
      // then a centred sphere, a sphere around the camera, and a tie between two
      // identical spheres where the earlier entry keeps the hit.
      pending_requests.push_back(trace_request(400, 300));
      pending_requests.push_back(load_request(0, 0, 0, 0, 256));
      pending_requests.push_back(load_request(1, 0, 0, -1280, 512));
      pending_requests.push_back(load_request(2, 0, 0, 0, 256));
      pending_requests.push_back(load_request(3, 32767, -32768, 32767, 65535));
      drain();
      write_register(CSR_ACTIVE_SPHERES, 16'd1);
      pending_requests.push_back(trace_request(400, 300));
      pending_requests.push_back(trace_request(0, 0));
      pending_requests.push_back(trace_request(4095, 4095));
      pending_requests.push_back(trace_request(350, 250));
      drain();
      // Camera inside the second sphere: that one misses, the first still hits.
      write_register(CSR_ACTIVE_SPHERES, 16'd2);
      pending_requests.push_back(trace_request(400, 300));
      pending_requests.push_back(load_request(1, 0, 0, 0, 256));
      pending_requests.push_back(trace_request(400, 300));
      drain();
      // More active spheres than table entries, and extreme camera positions.
      write_register(CSR_ACTIVE_SPHERES, 16'd7);
      pending_requests.push_back(trace_request(400, 300));
      pending_requests.push_back(trace_request(4095, 0));
      drain();
      write_register(CSR_CAMERA_Z, 16'h8000);
      pending_requests.push_back(trace_request(400, 300));
      drain();
      write_register(CSR_CAMERA_Z, 16'h7FFF);
      pending_requests.push_back(trace_request(400, 300));
      drain();
      // Zero width and height behave as one.
      write_register(CSR_IMAGE_WIDTH, 16'd0);
      write_register(CSR_IMAGE_HEIGHT, 16'd0);
      write_register(CSR_CAMERA_Z, -16'sd1280);
      pending_requests.push_back(trace_request(0, 0));
      pending_requests.push_back(trace_request(1, 4095));
      drain();

      // Random phases over several image sizes and camera positions. Most loads
      // place spheres in view; a few take any value at all. Pixels are mostly
      // inside the image so that hits are common.
      for (int phase = 0; phase < 12; phase++) begin
         phase_active = (phase % 6 == 5) ? 0 : 1 + (phase % 4);
         write_register(CSR_IMAGE_WIDTH, 16'(dims[phase % 4][0]));
         write_register(CSR_IMAGE_HEIGHT, 16'(dims[phase % 4][1]));
         write_register(CSR_CAMERA_Z, (phase % 5 == 4) ? 16'($urandom) :
                        16'(-256 * $urandom_range(2, 8)));
         write_register(CSR_ACTIVE_SPHERES, 16'(phase_active));
         for (int s = 0; s < MAX_SPHERES; s++) begin
            pending_requests.push_back(($urandom_range(0, 9) == 0) ? any_sphere(s) :
                                       visible_sphere(s));
         end
         for (int n = 0; n < 75; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               pending_requests.push_back(($urandom_range(0, 3) == 0) ?
                  any_sphere($urandom_range(0, 3)) : visible_sphere($urandom_range(0, 3)));
            end else if ($urandom_range(0, 9) == 0) begin
               pending_requests.push_back(trace_request($urandom_range(0, 4095),
                                                        $urandom_range(0, 4095)));
            end else begin
               dx = $urandom_range(0, dims[phase % 4][0] - 1);
               dy = $urandom_range(0, dims[phase % 4][1] - 1);
               pending_requests.push_back(trace_request(dx, dy));
            end
         end
         drain();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
`default_nettype wire
